// ===== hw/rtl/bbcb_pkg.sv =====
// Package for the bilevel bitmap compose and blit block.
// Holds plane sizes, field codes, the sequencer state type and the pixel helpers.
// Depends on nothing; the top level and its RAM instances take their sizes from here.
package bbcb_pkg;

    // Largest plane that the block stores
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // Derived plane geometry
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int XCW   = $clog2(MAX_WIDTH + 1);
    localparam int YCW   = $clog2(MAX_HEIGHT + 1);

    // Width of the signed clipping arithmetic
    localparam int CW = 20;

    // Configuration registers
    localparam int                 REG_W     = 9;
    localparam logic [REG_W-1:0]   REG_RESET = 9'd256;
    localparam logic [1:0]         REG_SRC_W = 2'd0;
    localparam logic [1:0]         REG_SRC_H = 2'd1;
    localparam logic [1:0]         REG_DST_W = 2'd2;
    localparam logic [1:0]         REG_DST_H = 2'd3;

    // Request kinds
    localparam logic [1:0] FUNC_WR_SRC  = 2'd0;
    localparam logic [1:0] FUNC_WR_DST  = 2'd1;
    localparam logic [1:0] FUNC_COMPOSE = 2'd2;
    localparam logic [1:0] FUNC_RD_DST  = 2'd3;

    // Combination operators; every other code replaces
    localparam logic [2:0] OP_OR   = 3'd0;
    localparam logic [2:0] OP_AND  = 3'd1;
    localparam logic [2:0] OP_XOR  = 3'd2;
    localparam logic [2:0] OP_XNOR = 3'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIP_EDGE,
        ST_CLIP_OFFS,
        ST_CLIP_ADJ,
        ST_CLIP_SIZE,
        ST_CLIP_END,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_READ_WAIT,
        ST_RESP
    } state_t;

    // Effective image dimension: the register value capped at the plane size.
    function automatic logic [REG_W-1:0] eff_dim(logic [REG_W-1:0] r, int cap);
        logic [REG_W-1:0] res;
        res = (int'(r) > cap) ? REG_W'(cap) : r;
        return res;
    endfunction

    // Linear RAM address of a pixel.
    function automatic logic [AW-1:0] pix_addr(logic [XW-1:0] x, logic [YW-1:0] y);
        logic [AW-1:0] a;
        a = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
        return a;
    endfunction

    // Combine a source bit into a destination bit.
    function automatic logic combine(logic [2:0] op, logic s, logic d);
        logic res;
        case (op)
            OP_OR:   res = s | d;
            OP_AND:  res = s & d;
            OP_XOR:  res = s ^ d;
            OP_XNOR: res = ~(s ^ d);
            default: res = s;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/bbcb_bitram.sv =====
// Generic one-bit-wide RAM with one write port and one registered read port.
// Used for the source and destination planes; depends on no package.
// Contents are undefined until written; the top level clears it after reset.
module bbcb_bitram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bilevel_bitmap_compose_blit.sv =====
// Top level of the bilevel bitmap compose and blit block.
// Depends on bbcb_pkg for sizes, codes and helpers, and on bbcb_bitram for the two planes.
//
// The block keeps a source and a destination one-bit plane of MAX_WIDTH by MAX_HEIGHT
// pixels, each in a single-port-write RAM with a registered read. After reset it runs a
// clearing pass over all MAX_WIDTH*MAX_HEIGHT addresses (65536 at the default size),
// zeroing both planes; requests are held off during it, while register writes are taken
// as ever. The block works on one request at a time. A pixel read passes through
// ST_READ_WAIT for the registered RAM read. A composition runs the clipping arithmetic
// through the sequencer states CLIP_EDGE, CLIP_OFFS, CLIP_ADJ, CLIP_SIZE and CLIP_END,
// then a read of both planes and a write of the destination per pixel covered after
// clipping, then the response. A rejected or fully clipped composition goes from
// clipping straight to the response. The result sits in an output register, so the
// next request is taken while it waits to be collected.
module bilevel_bitmap_compose_blit (
    input  logic          clk,
    input  logic          rst_n,
    // Request stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // s_tdata, from bit 0 up: pixel_x[15:0], pixel_y[31:16], pixel_value[32],
    // dest_x[48:33], dest_y[64:49], rect_left[80:65], rect_top[96:81],
    // rect_right[112:97], rect_bottom[128:113], compose_op[131:129], zero pad[135:132]
    input  logic [135:0]  s_tdata,
    // s_tuser: func[1:0]
    input  logic [1:0]    s_tuser,
    // Result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // m_tdata, from bit 0 up: read_bit[0], status[1], zero pad[7:2]
    output logic [7:0]    m_tdata,
    // Configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int CW  = bbcb_pkg::CW;
    localparam int XW  = bbcb_pkg::XW;
    localparam int YW  = bbcb_pkg::YW;
    localparam int XCW = bbcb_pkg::XCW;
    localparam int YCW = bbcb_pkg::YCW;
    localparam int AW  = bbcb_pkg::AW;
    localparam int RW  = bbcb_pkg::REG_W;

    // Request fields
    logic        [1:0]  in_func;
    logic signed [15:0] in_px;
    logic signed [15:0] in_py;
    logic               in_pv;
    logic signed [15:0] in_dx;
    logic signed [15:0] in_dy;
    logic signed [15:0] in_l;
    logic signed [15:0] in_t;
    logic signed [15:0] in_r;
    logic signed [15:0] in_b;
    logic        [2:0]  in_op;

    assign in_func = s_tuser;
    assign in_px   = s_tdata[15:0];
    assign in_py   = s_tdata[31:16];
    assign in_pv   = s_tdata[32];
    assign in_dx   = s_tdata[48:33];
    assign in_dy   = s_tdata[64:49];
    assign in_l    = s_tdata[80:65];
    assign in_t    = s_tdata[96:81];
    assign in_r    = s_tdata[112:97];
    assign in_b    = s_tdata[128:113];
    assign in_op   = s_tdata[131:129];

    // Sequencer and control registers
    bbcb_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_read_bit_reg, out_read_bit_next;
    logic             out_status_reg, out_status_next;

    // Configuration registers
    logic [RW-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;

    // Payload registers
    logic                 res_read_bit_reg, res_read_bit_next;
    logic                 res_status_reg, res_status_next;
    logic                 rd_hit_reg, rd_hit_next;
    logic [2:0]           op_reg, op_next;
    logic signed [15:0]   dx_reg, dy_reg, l_reg, t_reg, r_reg, b_reg;
    logic signed [15:0]   dx_next, dy_next, l_next, t_next, r_next, b_next;
    logic signed [CW-1:0] sl_reg, st_reg, sr_reg, sb_reg, dl_reg, dt_reg, cw_reg, ch_reg;
    logic signed [CW-1:0] sl_next, st_next, sr_next, sb_next;
    logic signed [CW-1:0] dl_next, dt_next, cw_next, ch_next;
    logic [XW-1:0]        sx_reg, sx0_reg, tx_reg, tx0_reg;
    logic [XW-1:0]        sx_next, sx0_next, tx_next, tx0_next;
    logic [YW-1:0]        sy_reg, ty_reg, sy_next, ty_next;
    logic [XCW-1:0]       tx_end_reg, tx_end_next;
    logic [YCW-1:0]       ty_end_reg, ty_end_next;

    // RAM ports
    logic          src_we, src_wdata, src_rdata;
    logic [AW-1:0] src_waddr, src_raddr;
    logic          dst_we, dst_wdata, dst_rdata;
    logic [AW-1:0] dst_waddr, dst_raddr;

    // Effective dimensions and their signed forms for clipping
    logic [RW-1:0]        sw_eff, sh_eff, dw_eff, dh_eff;
    logic signed [CW-1:0] sw_c, sh_c, dw_c, dh_c;

    assign sw_eff = bbcb_pkg::eff_dim(src_w_reg, bbcb_pkg::MAX_WIDTH);
    assign sh_eff = bbcb_pkg::eff_dim(src_h_reg, bbcb_pkg::MAX_HEIGHT);
    assign dw_eff = bbcb_pkg::eff_dim(dst_w_reg, bbcb_pkg::MAX_WIDTH);
    assign dh_eff = bbcb_pkg::eff_dim(dst_h_reg, bbcb_pkg::MAX_HEIGHT);
    assign sw_c   = CW'(sw_eff);
    assign sh_c   = CW'(sh_eff);
    assign dw_c   = CW'(dw_eff);
    assign dh_c   = CW'(dh_eff);

    // Pixel access hit tests against the source and destination images
    logic signed [CW-1:0] px_c, py_c;
    logic                 src_hit, dst_hit;
    logic [AW-1:0]        in_addr;

    assign px_c    = CW'(in_px);
    assign py_c    = CW'(in_py);
    assign src_hit = (px_c >= 0) && (px_c < sw_c) && (py_c >= 0) && (py_c < sh_c);
    assign dst_hit = (px_c >= 0) && (px_c < dw_c) && (py_c >= 0) && (py_c < dh_c);
    assign in_addr = bbcb_pkg::pix_addr(in_px[XW-1:0], in_py[YW-1:0]);

    // Clipping arithmetic, one small step per sequencer state
    logic signed [CW-1:0] l_c, t_c, r_c, b_c, dx_c, dy_c;
    logic signed [CW-1:0] xe_c, ye_c, xend_c, yend_c;
    logic                 rect_empty, clip_empty;

    assign l_c        = CW'(l_reg);
    assign t_c        = CW'(t_reg);
    assign r_c        = CW'(r_reg);
    assign b_c        = CW'(b_reg);
    assign dx_c       = CW'(dx_reg);
    assign dy_c       = CW'(dy_reg);
    assign rect_empty = (r_c <= l_c) || (b_c <= t_c);
    assign xe_c       = dl_reg + cw_reg;
    assign ye_c       = dt_reg + ch_reg;
    assign xend_c     = (xe_c > dw_c) ? dw_c : xe_c;
    assign yend_c     = (ye_c > dh_c) ? dh_c : ye_c;
    assign clip_empty = (xend_c <= dl_reg) || (yend_c <= dt_reg);

    // Walk position and its wrap tests
    logic [AW-1:0] walk_src_addr, walk_dst_addr;
    logic          last_col, last_row, new_bit;

    assign walk_src_addr = bbcb_pkg::pix_addr(sx_reg, sy_reg);
    assign walk_dst_addr = bbcb_pkg::pix_addr(tx_reg, ty_reg);
    assign last_col      = (XCW'(tx_reg) + XCW'(1)) == tx_end_reg;
    assign last_row      = (YCW'(ty_reg) + YCW'(1)) == ty_end_reg;
    assign new_bit       = bbcb_pkg::combine(op_reg, src_rdata, dst_rdata);

    logic accept;
    assign accept = s_tvalid && s_tready;

    // Next state, datapath steps and RAM port control
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_read_bit_next = out_read_bit_reg;
        out_status_next   = out_status_reg;
        res_read_bit_next = res_read_bit_reg;
        res_status_next   = res_status_reg;
        rd_hit_next       = rd_hit_reg;
        op_next           = op_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        l_next            = l_reg;
        t_next            = t_reg;
        r_next            = r_reg;
        b_next            = b_reg;
        sl_next           = sl_reg;
        st_next           = st_reg;
        sr_next           = sr_reg;
        sb_next           = sb_reg;
        dl_next           = dl_reg;
        dt_next           = dt_reg;
        cw_next           = cw_reg;
        ch_next           = ch_reg;
        sx_next           = sx_reg;
        sx0_next          = sx0_reg;
        tx_next           = tx_reg;
        tx0_next          = tx0_reg;
        sy_next           = sy_reg;
        ty_next           = ty_reg;
        tx_end_next       = tx_end_reg;
        ty_end_next       = ty_end_reg;

        src_we    = 1'b0;
        src_waddr = in_addr;
        src_wdata = in_pv;
        src_raddr = walk_src_addr;
        dst_we    = 1'b0;
        dst_waddr = in_addr;
        dst_wdata = in_pv;
        dst_raddr = walk_dst_addr;

        case (state_reg)
            // Zero both planes, one address per cycle
            bbcb_pkg::ST_CLEAR:
            begin
                src_we       = 1'b1;
                src_waddr    = clr_cnt_reg;
                src_wdata    = 1'b0;
                dst_we       = 1'b1;
                dst_waddr    = clr_cnt_reg;
                dst_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(bbcb_pkg::DEPTH - 1))
                begin
                    state_next = bbcb_pkg::ST_IDLE;
                end
            end

            // Take a request; pixel writes complete here
            bbcb_pkg::ST_IDLE:
            begin
                dst_raddr = in_addr;
                if (accept)
                begin
                    res_read_bit_next = 1'b0;
                    res_status_next   = 1'b0;
                    op_next           = in_op;
                    dx_next           = in_dx;
                    dy_next           = in_dy;
                    l_next            = in_l;
                    t_next            = in_t;
                    r_next            = in_r;
                    b_next            = in_b;
                    rd_hit_next       = dst_hit;
                    case (in_func)
                        bbcb_pkg::FUNC_WR_SRC:
                        begin
                            src_we     = src_hit;
                            state_next = bbcb_pkg::ST_RESP;
                        end
                        bbcb_pkg::FUNC_WR_DST:
                        begin
                            dst_we     = dst_hit;
                            state_next = bbcb_pkg::ST_RESP;
                        end
                        bbcb_pkg::FUNC_COMPOSE:
                        begin
                            state_next = bbcb_pkg::ST_CLIP_EDGE;
                        end
                        default:
                        begin
                            state_next = bbcb_pkg::ST_READ_WAIT;
                        end
                    endcase
                end
            end

            // Reject an empty rectangle, else clip it to the source image
            bbcb_pkg::ST_CLIP_EDGE:
            begin
                if (rect_empty)
                begin
                    res_status_next = 1'b1;
                    state_next      = bbcb_pkg::ST_RESP;
                end
                else
                begin
                    sl_next    = (l_c > 0) ? l_c : '0;
                    st_next    = (t_c > 0) ? t_c : '0;
                    sr_next    = (r_c < sw_c) ? r_c : sw_c;
                    sb_next    = (b_c < sh_c) ? b_c : sh_c;
                    state_next = bbcb_pkg::ST_CLIP_OFFS;
                end
            end

            // Place the clipped corner in the destination
            bbcb_pkg::ST_CLIP_OFFS:
            begin
                dl_next    = dx_c + sl_reg - l_c;
                dt_next    = dy_c + st_reg - t_c;
                state_next = bbcb_pkg::ST_CLIP_ADJ;
            end

            // Pull the corner inside the destination's top and left edges
            bbcb_pkg::ST_CLIP_ADJ:
            begin
                if (dl_reg < 0)
                begin
                    sl_next = sl_reg - dl_reg;
                    dl_next = '0;
                end
                if (dt_reg < 0)
                begin
                    st_next = st_reg - dt_reg;
                    dt_next = '0;
                end
                state_next = bbcb_pkg::ST_CLIP_SIZE;
            end

            bbcb_pkg::ST_CLIP_SIZE:
            begin
                cw_next    = sr_reg - sl_reg;
                ch_next    = sb_reg - st_reg;
                state_next = bbcb_pkg::ST_CLIP_END;
            end

            // Clip to the right and bottom edges and set up the walk
            bbcb_pkg::ST_CLIP_END:
            begin
                if (clip_empty)
                begin
                    state_next = bbcb_pkg::ST_RESP;
                end
                else
                begin
                    sx_next     = sl_reg[XW-1:0];
                    sx0_next    = sl_reg[XW-1:0];
                    sy_next     = st_reg[YW-1:0];
                    tx_next     = dl_reg[XW-1:0];
                    tx0_next    = dl_reg[XW-1:0];
                    ty_next     = dt_reg[YW-1:0];
                    tx_end_next = xend_c[XCW-1:0];
                    ty_end_next = yend_c[YCW-1:0];
                    state_next  = bbcb_pkg::ST_PIX_RD;
                end
            end

            // Read both planes at the current pixel
            bbcb_pkg::ST_PIX_RD:
            begin
                state_next = bbcb_pkg::ST_PIX_WR;
            end

            // Write the combined bit back and step raster order
            bbcb_pkg::ST_PIX_WR:
            begin
                dst_we    = 1'b1;
                dst_waddr = walk_dst_addr;
                dst_wdata = new_bit;
                if (last_col)
                begin
                    tx_next = tx0_reg;
                    sx_next = sx0_reg;
                    ty_next = ty_reg + YW'(1);
                    sy_next = sy_reg + YW'(1);
                end
                else
                begin
                    tx_next = tx_reg + XW'(1);
                    sx_next = sx_reg + XW'(1);
                end
                if (last_col && last_row)
                begin
                    state_next = bbcb_pkg::ST_RESP;
                end
                else
                begin
                    state_next = bbcb_pkg::ST_PIX_RD;
                end
            end

            // Destination read data arrives in the cycle after the address
            bbcb_pkg::ST_READ_WAIT:
            begin
                res_read_bit_next = rd_hit_reg & dst_rdata;
                state_next        = bbcb_pkg::ST_RESP;
            end

            // Hand the result to the output register once it is free
            bbcb_pkg::ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next    = 1'b1;
                    out_read_bit_next = res_read_bit_reg;
                    out_status_next   = res_status_reg;
                    state_next        = bbcb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bbcb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbcb_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_read_bit_reg <= out_read_bit_next;
        out_status_reg   <= out_status_next;
        res_read_bit_reg <= res_read_bit_next;
        res_status_reg   <= res_status_next;
        rd_hit_reg       <= rd_hit_next;
        op_reg           <= op_next;
        dx_reg           <= dx_next;
        dy_reg           <= dy_next;
        l_reg            <= l_next;
        t_reg            <= t_next;
        r_reg            <= r_next;
        b_reg            <= b_next;
        sl_reg           <= sl_next;
        st_reg           <= st_next;
        sr_reg           <= sr_next;
        sb_reg           <= sb_next;
        dl_reg           <= dl_next;
        dt_reg           <= dt_next;
        cw_reg           <= cw_next;
        ch_reg           <= ch_next;
        sx_reg           <= sx_next;
        sx0_reg          <= sx0_next;
        tx_reg           <= tx_next;
        tx0_reg          <= tx0_next;
        sy_reg           <= sy_next;
        ty_reg           <= ty_next;
        tx_end_reg       <= tx_end_next;
        ty_end_reg       <= ty_end_next;
    end

    // Configuration registers, written on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= bbcb_pkg::REG_RESET;
            src_h_reg <= bbcb_pkg::REG_RESET;
            dst_w_reg <= bbcb_pkg::REG_RESET;
            dst_h_reg <= bbcb_pkg::REG_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                bbcb_pkg::REG_SRC_W: src_w_reg <= pwdata[RW-1:0];
                bbcb_pkg::REG_SRC_H: src_h_reg <= pwdata[RW-1:0];
                bbcb_pkg::REG_DST_W: dst_w_reg <= pwdata[RW-1:0];
                default:             dst_h_reg <= pwdata[RW-1:0];
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (paddr[3:2])
            bbcb_pkg::REG_SRC_W: prdata = 32'(src_w_reg);
            bbcb_pkg::REG_SRC_H: prdata = 32'(src_h_reg);
            bbcb_pkg::REG_DST_W: prdata = 32'(dst_w_reg);
            default:             prdata = 32'(dst_h_reg);
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == bbcb_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_status_reg, out_read_bit_reg};

    // Plane storage
    bbcb_bitram #(
        .DEPTH (bbcb_pkg::DEPTH),
        .AW    (AW)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_waddr),
        .wdata (src_wdata),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    bbcb_bitram #(
        .DEPTH (bbcb_pkg::DEPTH),
        .AW    (AW)
    ) u_dst_ram (
        .clk   (clk),
        .we    (dst_we),
        .waddr (dst_waddr),
        .wdata (dst_wdata),
        .raddr (dst_raddr),
        .rdata (dst_rdata)
    );

`ifndef SYNTHESIS
    // A walk write always lands inside the destination image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bbcb_pkg::ST_PIX_WR) |->
            ((CW'(tx_reg) < dw_c) && (CW'(ty_reg) < dh_c)))
        else $error("compose write outside destination image");

    // A walk read always fetches from inside the source image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bbcb_pkg::ST_PIX_RD) |->
            ((CW'(sx_reg) < sw_c) && (CW'(sy_reg) < sh_c)))
        else $error("compose read outside source image");

    // Read data and reject status never come from the same request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_read_bit_reg && out_status_reg))
        else $error("result carries both read bit and status");

    // The block takes one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");
`endif

endmodule
